FILE: rtl/bcdclk_pkg.sv
// Shared constants and types for the BCD time-of-day clock.
package bcdclk_pkg;

	localparam int unsigned IN_BITS  = 4;
	localparam int unsigned IN_BYTES = (IN_BITS + 7) / 8;
	localparam int unsigned OUT_BITS = 24;
	localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

	localparam logic [7:0] TPS_RESET = 8'd100;

	// Column codes for the digit being set.
	localparam logic [2:0] COL_SEC_UNITS  = 3'd0;
	localparam logic [2:0] COL_SEC_TENS   = 3'd1;
	localparam logic [2:0] COL_MIN_UNITS  = 3'd2;
	localparam logic [2:0] COL_MIN_TENS   = 3'd3;
	localparam logic [2:0] COL_HOUR_UNITS = 3'd4;
	localparam logic [2:0] COL_HOUR_TENS  = 3'd5;

	// Last value of each digit before it wraps, and the hour-units value that wraps hour 2x.
	localparam logic [3:0] UNITS_LAST   = 4'd9;
	localparam logic [2:0] TENS_LAST    = 3'd5;
	localparam logic [1:0] HTENS_LAST   = 2'd2;
	localparam logic [3:0] HUNITS_WRAP  = 4'd4;

	typedef struct packed {
		logic [1:0] hour_tens;
		logic [3:0] hour_units;
		logic [2:0] min_tens;
		logic [3:0] min_units;
		logic [2:0] sec_tens;
		logic [3:0] sec_units;
	} clock_time_t;

	localparam clock_time_t TIME_RESET = '{
		hour_tens:  2'd1,
		hour_units: 4'd1,
		min_tens:   3'd1,
		min_units:  4'd1,
		sec_tens:   3'd1,
		sec_units:  4'd0
	};

endpackage

FILE: rtl/bcd_clock_with_set_buttons_unit.sv
// BCD 24-hour clock with run/set switch and two set buttons: top level.
//
// Usage:
//   s_axis carries one sample period per transfer. tdata bit 0 is tick,
//   bit 1 run_switch_n, bit 2 column_button_n, bit 3 add_button_n.
//   m_axis returns one transfer per sample with all six BCD digits, the
//   selected digit and the setting flag, taken after that sample's update.
//   cfg_valid/cfg_ready/cfg_data writes ticks_per_second (0 acts like 1);
//   cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A sample accepted on s_axis lands in the input register, and its
//   result is registered in the clock state once the output is free or
//   taken. The clock state registers double as the result register, so one
//   sample per cycle is sustained while m_axis_tready is high; the carry chain through the six digits sets the path.
// Reset:
//   arst_n clears both stages, sets the time to 11:11:10, column 0, the
//   prescaler to 0 and ticks_per_second to 100.
// Stall:
//   While m_axis_tready is low the result and clock state hold; at most one
//   more sample is taken into the input register, then s_axis_tready drops.
module bcd_clock_with_set_buttons_unit
	import bcdclk_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// tick, run_switch_n, column_button_n, add_button_n, zero pad
	input  logic [IN_BYTES*8-1:0]    s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// sec_units[3:0], sec_tens[6:4], min_units[10:7], min_tens[13:11],
	// hour_units[17:14], hour_tens[19:18], selected_digit[22:20], setting_mode[23]
	output logic [OUT_BYTES*8-1:0]   m_axis_tdata,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [7:0]               cfg_data
);

	logic        valid_s1;
	logic        tick_s1, run_s1, col_lvl_s1, add_lvl_s1;
	logic        out_valid_q;
	logic        advance;
	logic [7:0]  tps_q;
	logic [7:0]  presc_q, presc_d;
	clock_time_t time_q, time_d, tick_time, set_time;
	logic [2:0]  col_q, col_d;
	logic        col_held_q, add_held_q;
	logic        mode_q;
	logic [8:0]  presc_inc;
	logic        sec_pulse;
	logic        col_fall, add_fall;
	logic        c_su, c_st, c_mu, c_mt;
	logic [3:0]  hu_inc;
	logic [2:0]  ht_inc;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {mode_q, col_q, time_q};

	// Run mode: prescaler and carry chain.
	always_comb begin
		presc_inc = {1'b0, presc_q} + 9'd1;
		sec_pulse = tick_s1 && (presc_inc >= {1'b0, tps_q});
		c_su = time_q.sec_units >= UNITS_LAST;
		c_st = c_su && (time_q.sec_tens >= TENS_LAST);
		c_mu = c_st && (time_q.min_units >= UNITS_LAST);
		c_mt = c_mu && (time_q.min_tens >= TENS_LAST);
		tick_time = time_q;
		tick_time.sec_units = c_su ? 4'd0 : time_q.sec_units + 4'd1;
		if (c_su) begin
			tick_time.sec_tens = c_st ? 3'd0 : time_q.sec_tens + 3'd1;
		end
		if (c_st) begin
			tick_time.min_units = c_mu ? 4'd0 : time_q.min_units + 4'd1;
		end
		if (c_mu) begin
			tick_time.min_tens = c_mt ? 3'd0 : time_q.min_tens + 3'd1;
		end
		hu_inc = time_q.hour_units + 4'd1;
		ht_inc = {1'b0, time_q.hour_tens};
		if (time_q.hour_units >= UNITS_LAST) begin
			hu_inc = 4'd0;
			ht_inc = {1'b0, time_q.hour_tens} + 3'd1;
		end
		if (c_mt) begin
			// Wrap 24:00 and any hand-set hour past it to midnight.
			if (ht_inc > {1'b0, HTENS_LAST} ||
			    (ht_inc == {1'b0, HTENS_LAST} && hu_inc >= HUNITS_WRAP)) begin
				tick_time.hour_units = 4'd0;
				tick_time.hour_tens  = 2'd0;
			end else begin
				tick_time.hour_units = hu_inc;
				tick_time.hour_tens  = ht_inc[1:0];
			end
		end
	end

	// Set mode: button edges, column select, per-digit bump without carry.
	always_comb begin
		col_fall = !col_lvl_s1 && !col_held_q;
		add_fall = !add_lvl_s1 && !add_held_q;
		col_d = col_q;
		if (col_fall) begin
			col_d = (col_q >= COL_HOUR_TENS) ? COL_SEC_UNITS : col_q + 3'd1;
		end
		set_time = time_q;
		if (add_fall) begin
			case (col_d)
				COL_SEC_UNITS: set_time.sec_units =
					(time_q.sec_units >= UNITS_LAST) ? 4'd0 : time_q.sec_units + 4'd1;
				COL_SEC_TENS: set_time.sec_tens =
					(time_q.sec_tens >= TENS_LAST) ? 3'd0 : time_q.sec_tens + 3'd1;
				COL_MIN_UNITS: set_time.min_units =
					(time_q.min_units >= UNITS_LAST) ? 4'd0 : time_q.min_units + 4'd1;
				COL_MIN_TENS: set_time.min_tens =
					(time_q.min_tens >= TENS_LAST) ? 3'd0 : time_q.min_tens + 3'd1;
				COL_HOUR_UNITS: set_time.hour_units =
					(time_q.hour_units >= UNITS_LAST) ? 4'd0 : time_q.hour_units + 4'd1;
				default: set_time.hour_tens =
					(time_q.hour_tens >= HTENS_LAST) ? 2'd0 : time_q.hour_tens + 2'd1;
			endcase
		end
	end

	always_comb begin
		presc_d = presc_q;
		time_d  = time_q;
		if (run_s1) begin
			if (tick_s1) begin
				presc_d = sec_pulse ? 8'd0 : presc_inc[7:0];
			end
			if (sec_pulse) begin
				time_d = tick_time;
			end
		end else begin
			time_d = set_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			tick_s1    <= 1'b0;
			run_s1     <= 1'b1;
			col_lvl_s1 <= 1'b1;
			add_lvl_s1 <= 1'b1;
		end else if (s_axis_tready) begin
			valid_s1   <= s_axis_tvalid;
			tick_s1    <= s_axis_tdata[0];
			run_s1     <= s_axis_tdata[1];
			col_lvl_s1 <= s_axis_tdata[2];
			add_lvl_s1 <= s_axis_tdata[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tps_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			presc_q     <= 8'd0;
			time_q      <= TIME_RESET;
			col_q       <= COL_SEC_UNITS;
			col_held_q  <= 1'b0;
			add_held_q  <= 1'b0;
			mode_q      <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				presc_q     <= presc_d;
				time_q      <= time_d;
				mode_q      <= !run_s1;
				if (!run_s1) begin
					col_q      <= col_d;
					col_held_q <= !col_lvl_s1;
					add_held_q <= !add_lvl_s1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the prescaler in set mode.
	a_presc_hold_set: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !run_s1) |=> $stable(presc_q))
		else $error("prescaler moved in set mode");

	// Hold the clock state while a result waits.
	a_state_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> ($stable(time_q) && $stable(col_q)))
		else $error("clock state changed under a stalled result");

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_HOUR_TENS)
		else $error("selected column out of range");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(time_q.sec_units <= UNITS_LAST) && (time_q.sec_tens <= TENS_LAST) &&
		(time_q.min_units <= UNITS_LAST) && (time_q.min_tens <= TENS_LAST) &&
		(time_q.hour_units <= UNITS_LAST) && (time_q.hour_tens <= HTENS_LAST))
		else $error("BCD digit out of range");

	// Drop input ready only when the input register is stuck behind the output.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input ready dropped without a stall");

endmodule

FILE: tb/bcd_clock_with_set_buttons_unit_tb.sv
// Self-checking testbench for the BCD time-of-day clock with set buttons.
`timescale 1ns / 100ps

module bcd_clock_with_set_buttons_unit_tb;
	import bcdclk_pkg::*;

	typedef struct packed {
		logic        setting_mode;
		logic [2:0]  selected_digit;
		clock_time_t tod;
	} clock_readout_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// tick, run_switch_n, column_button_n, add_button_n, zero pad
	logic [IN_BYTES*8-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// sec_units, sec_tens, min_units, min_tens, hour_units, hour_tens,
	// selected_digit, setting_mode
	logic [OUT_BYTES*8-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [7:0]             cfg_data = '0;

	// clock model state
	logic [7:0]  ticks_per_sec_q;
	logic [7:0]  prescale_q;
	clock_time_t tod_q;
	logic [2:0]  column_q;
	logic        column_down_q;
	logic        add_down_q;

	clock_readout_t pending_readouts[$];

	bit steady = 1'b0;
	int n_samples = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_hour_carries = 0;
	int n_midnight_wraps = 0;
	int n_rate_writes = 0;

	bcd_clock_with_set_buttons_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic coin(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	always @(posedge clk) begin
		m_axis_tready <= steady || !coin(36);
	end

	function automatic clock_time_t make_tod(input int ht, input int hu, input int mt,
			input int mu, input int st, input int su);
		clock_time_t t;
		t.hour_tens  = 2'(ht);
		t.hour_units = 4'(hu);
		t.min_tens   = 3'(mt);
		t.min_units  = 4'(mu);
		t.sec_tens   = 3'(st);
		t.sec_units  = 4'(su);
		return t;
	endfunction

	function automatic int digit_value(input clock_time_t t, input int c);
		case (c)
			COL_SEC_UNITS:  return int'(t.sec_units);
			COL_SEC_TENS:   return int'(t.sec_tens);
			COL_MIN_UNITS:  return int'(t.min_units);
			COL_MIN_TENS:   return int'(t.min_tens);
			COL_HOUR_UNITS: return int'(t.hour_units);
			default:        return int'(t.hour_tens);
		endcase
	endfunction

	function automatic int digit_span(input int c);
		case (c)
			COL_SEC_TENS, COL_MIN_TENS: return int'(TENS_LAST) + 1;
			COL_HOUR_TENS:              return int'(HTENS_LAST) + 1;
			default:                    return int'(UNITS_LAST) + 1;
		endcase
	endfunction

	function automatic void reset_clock_model();
		ticks_per_sec_q = TPS_RESET;
		prescale_q      = '0;
		tod_q           = TIME_RESET;
		column_q        = COL_SEC_UNITS;
		column_down_q   = 1'b0;
		add_down_q      = 1'b0;
	endfunction

	function automatic void advance_second();
		if (tod_q.sec_units != UNITS_LAST) begin
			tod_q.sec_units++;
			return;
		end
		tod_q.sec_units = '0;
		if (tod_q.sec_tens != TENS_LAST) begin
			tod_q.sec_tens++;
			return;
		end
		tod_q.sec_tens = '0;
		if (tod_q.min_units != UNITS_LAST) begin
			tod_q.min_units++;
			return;
		end
		tod_q.min_units = '0;
		if (tod_q.min_tens != TENS_LAST) begin
			tod_q.min_tens++;
			return;
		end
		tod_q.min_tens = '0;
		n_hour_carries++;
		if (tod_q.hour_units == UNITS_LAST) begin
			tod_q.hour_units = '0;
			tod_q.hour_tens++;
		end else begin
			tod_q.hour_units++;
		end
		// hours set by hand above 23 also fall back to midnight
		if (tod_q.hour_tens > HTENS_LAST ||
				(tod_q.hour_tens == HTENS_LAST && tod_q.hour_units >= HUNITS_WRAP)) begin
			tod_q.hour_tens  = '0;
			tod_q.hour_units = '0;
			n_midnight_wraps++;
		end
	endfunction

	function automatic void add_to_column();
		case (column_q)
			COL_SEC_UNITS:
				tod_q.sec_units = (tod_q.sec_units == UNITS_LAST) ? 4'd0 : tod_q.sec_units + 4'd1;
			COL_SEC_TENS:
				tod_q.sec_tens = (tod_q.sec_tens == TENS_LAST) ? 3'd0 : tod_q.sec_tens + 3'd1;
			COL_MIN_UNITS:
				tod_q.min_units = (tod_q.min_units == UNITS_LAST) ? 4'd0 : tod_q.min_units + 4'd1;
			COL_MIN_TENS:
				tod_q.min_tens = (tod_q.min_tens == TENS_LAST) ? 3'd0 : tod_q.min_tens + 3'd1;
			COL_HOUR_UNITS:
				tod_q.hour_units = (tod_q.hour_units == UNITS_LAST) ? 4'd0
					: tod_q.hour_units + 4'd1;
			default:
				tod_q.hour_tens = (tod_q.hour_tens == HTENS_LAST) ? 2'd0 : tod_q.hour_tens + 2'd1;
		endcase
	endfunction

	// bits: tick, run_switch_n, column_button_n, add_button_n from bit 0 up
	function automatic void clock_step(input logic [3:0] bits);
		logic [8:0]     next_count;
		clock_readout_t r;
		if (bits[1]) begin
			if (bits[0]) begin
				next_count = {1'b0, prescale_q} + 9'd1;
				if (next_count >= {1'b0, ticks_per_sec_q}) begin
					prescale_q = '0;
					advance_second();
				end else begin
					prescale_q = next_count[7:0];
				end
			end
		end else begin
			// column moves first so a joint press adds to the new digit
			if (!bits[2] && !column_down_q) begin
				column_down_q = 1'b1;
				column_q = (column_q >= COL_HOUR_TENS) ? COL_SEC_UNITS : column_q + 3'd1;
			end else if (bits[2]) begin
				column_down_q = 1'b0;
			end
			if (!bits[3] && !add_down_q) begin
				add_down_q = 1'b1;
				add_to_column();
			end else if (bits[3]) begin
				add_down_q = 1'b0;
			end
		end
		r.setting_mode   = !bits[1];
		r.selected_digit = column_q;
		r.tod            = tod_q;
		pending_readouts.push_back(r);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin : check_readout
		clock_readout_t got;
		clock_readout_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_readouts.size() == 0) begin
				$error("readout %h with no sample pending", m_axis_tdata);
				n_errors++;
			end else begin
				want = pending_readouts.pop_front();
				n_checked++;
				check_field("sec_units", 32'(want.tod.sec_units), 32'(got.tod.sec_units));
				check_field("sec_tens", 32'(want.tod.sec_tens), 32'(got.tod.sec_tens));
				check_field("min_units", 32'(want.tod.min_units), 32'(got.tod.min_units));
				check_field("min_tens", 32'(want.tod.min_tens), 32'(got.tod.min_tens));
				check_field("hour_units", 32'(want.tod.hour_units),
					32'(got.tod.hour_units));
				check_field("hour_tens", 32'(want.tod.hour_tens), 32'(got.tod.hour_tens));
				check_field("selected_digit", 32'(want.selected_digit),
					32'(got.selected_digit));
				check_field("setting_mode", 32'(want.setting_mode), 32'(got.setting_mode));
			end
		end
	end

	task automatic send_sample(input logic [3:0] bits);
		while (!steady && coin(36)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_BYTES*8-4){1'b0}}, bits};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		clock_step(bits);
		n_samples++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rate(input logic [7:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		ticks_per_sec_q = value;
		n_rate_writes++;
	endtask

	// press a button in set mode, sometimes hold it a while, then release
	task automatic tap(input logic col_press, input logic add_press);
		int hold;
		hold = coin(25) ? $urandom_range(2, 4) : 1;
		repeat (hold) send_sample({!add_press, !col_press, 1'b0, coin(50)});
		send_sample({2'b11, 1'b0, coin(50)});
	endtask

	task automatic set_clock_to(input clock_time_t goal);
		int presses;
		int span;
		send_sample({2'b11, 1'b0, coin(50)});
		for (int c = 0; c < 6; c++) begin
			while (int'(column_q) != c) tap(1'b1, 1'b0);
			span = digit_span(c);
			presses = (digit_value(goal, c) - digit_value(tod_q, c) + span) % span;
			repeat (presses) tap(1'b0, 1'b1);
		end
	endtask

	task automatic run_burst(input int n, input int unsigned tick_pct);
		repeat (n) send_sample({coin(50), coin(50), 1'b1, coin(tick_pct)});
	endtask

	task automatic test_edge_cases();
		logic [3:0] opening[10];
		opening = '{4'b1110, 4'b1111, 4'b0000, 4'b0001, 4'b1101,
			4'b0011, 4'b1011, 4'b1001, 4'b0101, 4'b1100};
		// reset readout, joint press, buttons in run, ticks in set
		foreach (opening[i]) send_sample(opening[i]);
		write_rate(8'd1);
		repeat (3) send_sample(4'b1111);
		// zero rate behaves like one tick per second
		write_rate(8'd0);
		repeat (2) send_sample(4'b1111);
		write_rate(8'd255);
		repeat (3) send_sample(4'b1111);
		// rate dropped below the running count fires on the next tick
		write_rate(8'd2);
		repeat (2) send_sample(4'b1111);
	endtask

	task automatic test_hour_rollover();
		write_rate(8'd1);
		set_clock_to(make_tod(2, 3, 5, 9, 5, 8));
		run_burst(3, 100);
		set_clock_to(make_tod(2, 9, 5, 9, 5, 9));
		run_burst(2, 100);
		set_clock_to(make_tod(1, 9, 5, 9, 5, 9));
		run_burst(2, 100);
		set_clock_to(make_tod(0, 9, 5, 9, 5, 9));
		run_burst(2, 100);
	endtask

	task automatic test_random_use();
		int pick;
		clock_time_t goal;
		while (n_samples < 1350) begin
			steady = (n_samples >= 550 && n_samples < 800);
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				case ($urandom_range(0, 9))
					0:       write_rate(8'd255);
					1, 2, 3: write_rate(8'd1);
					4, 5, 6: write_rate(8'($urandom_range(2, 3)));
					default: write_rate(8'($urandom_range(1, 255)));
				endcase
			end else if (pick < 55) begin
				if (coin(35))
					goal = make_tod(2, $urandom_range(3, 9), 5, 9, 5, $urandom_range(5, 9));
				else
					goal = make_tod($urandom_range(0, 2), $urandom_range(0, 9),
						$urandom_range(0, 5), $urandom_range(0, 9),
						$urandom_range(0, 5), $urandom_range(0, 9));
				set_clock_to(goal);
				run_burst($urandom_range(10, 60), $urandom_range(50, 100));
			end else if (pick < 78) begin
				run_burst($urandom_range(5, 40), $urandom_range(0, 100));
			end else begin
				repeat ($urandom_range(5, 30)) send_sample(4'($urandom_range(0, 15)));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		reset_clock_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_cases();
		test_hour_rollover();
		test_random_use();
		wait_idle();
		$display("%0d samples sent and %0d readouts checked over %0d rate settings",
			n_samples, n_checked, n_rate_writes);
		$display("%0d carries into the hours, %0d of them wrapping to midnight",
			n_hour_carries, n_midnight_wraps);
		if (n_errors == 0) begin
			$display("bcd_clock_with_set_buttons_unit_tb: clean");
		end else begin
			$display("bcd_clock_with_set_buttons_unit_tb: errors");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d readouts pending", pending_readouts.size());
		$display("bcd_clock_with_set_buttons_unit_tb: errors");
		$finish;
	end

endmodule
